// ===== rtl/core/bwlp_pkg.sv =====
// Shared types, constants and helpers for the fourth-order low-pass filter.
// Used by the controller, the datapath and the top level.
package bwlp_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COEF_W      = 32;
  localparam int OUT_W       = 32;
  localparam int PROD_W      = 2 * COEF_W;
  localparam int SUM1_W      = SAMPLE_BITS + 2;
  localparam int FF_W        = PROD_W + 3;
  localparam int FRAC_COEF   = 28;
  localparam int FF1_SHIFT   = 12;
  localparam int FB_W        = PROD_W - FRAC_COEF;
  localparam int RES_W       = (SAMPLE_BITS + 24 > 40) ? SAMPLE_BITS + 24 : 40;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_GAIN    = 3'd0,
    CFG_FIRST_FB_ONE  = 3'd1,
    CFG_FIRST_FB_TWO  = 3'd2,
    CFG_SECOND_GAIN   = 3'd3,
    CFG_SECOND_FB_ONE = 3'd4,
    CFG_SECOND_FB_TWO = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    MUL_NONE = 4'd0,
    MUL_FF1  = 4'd1,
    MUL_FB11 = 4'd2,
    MUL_FB12 = 4'd3,
    MUL_FB21 = 4'd4,
    MUL_FB22 = 4'd5,
    MUL_FF2A = 4'd6,
    MUL_FF2B = 4'd7,
    MUL_FF2C = 4'd8
  } mul_sel_e;

  typedef enum logic [2:0] {
    RES_HOLD        = 3'd0,
    RES_LOAD_FF1    = 3'd1,
    RES_SUB_FB      = 3'd2,
    RES_LOAD_NEG_FB = 3'd3,
    RES_ADD_FF      = 3'd4
  } res_op_e;

  typedef enum logic [1:0] {
    FF_HOLD     = 2'd0,
    FF_LOAD_DBL = 2'd1,
    FF_ADD      = 2'd2
  } ff_op_e;

  typedef struct packed {
    logic     take;
    mul_sel_e mul_sel;
    res_op_e  res_op;
    ff_op_e   ff_op;
    logic     mid_load;
    logic     commit;
  } cmd_t;

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [RES_W-1:0] v);
    logic [RES_W-OUT_W:0] top;
    top = v[RES_W-1:OUT_W-1];
    if ((&top) || !(|top)) begin
      sat32 = v[OUT_W-1:0];
    end else if (v[RES_W-1]) begin
      sat32 = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/core/butterworth_lowpass_4th_order.sv =====
// Top level of the fourth-order Butterworth low-pass filter (two biquads).
// Depends on bwlp_pkg, bwlp_ctrl and bwlp_datapath.
//
//   channel    handshake                        payload
//   sample     sample_valid_i / sample_ready_o  sample_i    (16 bit signed)
//   filtered   filtered_valid_o / filtered_ready_i filtered_o (32 bit Q16.16)
//   cfg        cfg_valid_i / cfg_ready_o        cfg_index_i, cfg_data_i
//
// A new sample is taken only after the previous result has been committed:
// eight products pass one by one through a single shared 32x32 multiplier.
// The result is registered when the sequencer commits it in its DONE step.
// Reset clears coefficients and filter history to zero.
// A result stalled at the output holds the sequencer in its last step.
// Accept coefficient writes only while the sequencer is idle.
module butterworth_lowpass_4th_order (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    sample_valid_i,
  output logic                                    sample_ready_o,
  input  logic signed [bwlp_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                    filtered_valid_o,
  input  logic                                    filtered_ready_i,
  output logic signed [bwlp_pkg::OUT_W-1:0]       filtered_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [bwlp_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [bwlp_pkg::COEF_W-1:0]             cfg_data_i
);
  import bwlp_pkg::*;

  cmd_t cmd;

  assign cfg_ready_o = sample_ready_o;

  bwlp_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_valid_i   (sample_valid_i),
    .sample_ready_o   (sample_ready_o),
    .filtered_valid_o (filtered_valid_o),
    .filtered_ready_i (filtered_ready_i),
    .cmd_o            (cmd)
  );

  bwlp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_i    (sample_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .filtered_o  (filtered_o)
  );

endmodule

// ===== rtl/core/bwlp_ctrl.sv =====
// Sequencer for the two cascaded biquad sections and the result handshake.
// Depends on bwlp_pkg for the command struct and operation codes.
module bwlp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             sample_valid_i,
  output logic             sample_ready_o,
  output logic             filtered_valid_o,
  input  logic             filtered_ready_i,
  output bwlp_pkg::cmd_t   cmd_o
);
  import bwlp_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_C1   = 12'b0000_0000_0010,
    ST_C2   = 12'b0000_0000_0100,
    ST_C3   = 12'b0000_0000_1000,
    ST_C4   = 12'b0000_0001_0000,
    ST_C5   = 12'b0000_0010_0000,
    ST_C6   = 12'b0000_0100_0000,
    ST_C7   = 12'b0000_1000_0000,
    ST_C8   = 12'b0001_0000_0000,
    ST_C9   = 12'b0010_0000_0000,
    ST_C10  = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign sample_ready_o   = (state_q == ST_IDLE);
  assign filtered_valid_o = out_valid_q;
  assign out_free         = !out_valid_q || filtered_ready_i;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_NONE;
    cmd_o.res_op   = RES_HOLD;
    cmd_o.ff_op    = FF_HOLD;
    case (state_q)
      ST_IDLE: begin
        if (sample_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_C1;
        end
      end
      ST_C1: begin
        cmd_o.mul_sel = MUL_FF1;
        state_d       = ST_C2;
      end
      ST_C2: begin
        cmd_o.mul_sel = MUL_FB11;
        cmd_o.res_op  = RES_LOAD_FF1;
        state_d       = ST_C3;
      end
      ST_C3: begin
        cmd_o.mul_sel = MUL_FB12;
        cmd_o.res_op  = RES_SUB_FB;
        state_d       = ST_C4;
      end
      ST_C4: begin
        cmd_o.mul_sel = MUL_FB21;
        cmd_o.res_op  = RES_SUB_FB;
        state_d       = ST_C5;
      end
      ST_C5: begin
        cmd_o.mul_sel  = MUL_FB22;
        cmd_o.mid_load = 1'b1;
        cmd_o.res_op   = RES_LOAD_NEG_FB;
        state_d        = ST_C6;
      end
      ST_C6: begin
        cmd_o.mul_sel = MUL_FF2A;
        cmd_o.res_op  = RES_SUB_FB;
        state_d       = ST_C7;
      end
      ST_C7: begin
        cmd_o.mul_sel = MUL_FF2B;
        cmd_o.ff_op   = FF_LOAD_DBL;
        state_d       = ST_C8;
      end
      ST_C8: begin
        cmd_o.mul_sel = MUL_FF2C;
        cmd_o.ff_op   = FF_ADD;
        state_d       = ST_C9;
      end
      ST_C9: begin
        cmd_o.ff_op = FF_ADD;
        state_d     = ST_C10;
      end
      ST_C10: begin
        cmd_o.res_op = RES_ADD_FF;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !filtered_ready_i) || cmd_o.commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/bwlp_datapath.sv =====
// Coefficient registers, filter history, shared multiplier and accumulators.
// Depends on bwlp_pkg; driven by commands from bwlp_ctrl.
module bwlp_datapath (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  bwlp_pkg::cmd_t                           cmd_i,
  input  logic signed [bwlp_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic                                     cfg_we_i,
  input  logic [bwlp_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [bwlp_pkg::COEF_W-1:0]              cfg_data_i,
  output logic signed [bwlp_pkg::OUT_W-1:0]        filtered_o
);
  import bwlp_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF12   = PROD_W'(1) <<< (FF1_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] HALF28   = PROD_W'(1) <<< (FRAC_COEF - 1);
  localparam logic signed [FF_W-1:0]   HALF28_W = FF_W'(1) <<< (FRAC_COEF - 1);

  logic signed [COEF_W-1:0]      g1_q, a11_q, a12_q, g2_q, a21_q, a22_q;
  logic signed [SAMPLE_BITS-1:0] x_q, x1_q, x2_q;
  logic signed [OUT_W-1:0]       m_q, m1_q, m2_q, y1_q, y2_q, out_q;
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic signed [FF_W-1:0]        ff_q, ff_d;
  logic signed [RES_W-1:0]       res_q, res_d;

  logic signed [SUM1_W-1:0]      sum1;
  logic signed [COEF_W-1:0]      mul_a, mul_b;
  logic signed [PROD_W-1:0]      prod_r12, prod_r28;
  logic signed [FF_W-1:0]        ff_r;
  logic signed [FB_W-1:0]        fb_v;
  logic signed [FF_W-FRAC_COEF-1:0] ff_v;
  logic signed [RES_W-1:0]       ff1_term, fb_term, ff2_term;
  logic signed [OUT_W-1:0]       y_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_q  <= '0;
      a11_q <= '0;
      a12_q <= '0;
      g2_q  <= '0;
      a21_q <= '0;
      a22_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FIRST_GAIN:    g1_q  <= cfg_data_i;
        CFG_FIRST_FB_ONE:  a11_q <= cfg_data_i;
        CFG_FIRST_FB_TWO:  a12_q <= cfg_data_i;
        CFG_SECOND_GAIN:   g2_q  <= cfg_data_i;
        CFG_SECOND_FB_ONE: a21_q <= cfg_data_i;
        CFG_SECOND_FB_TWO: a22_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sum1 = {{2{x_q[SAMPLE_BITS-1]}}, x_q}
              + {x1_q[SAMPLE_BITS-1], x1_q, 1'b0}
              + {{2{x2_q[SAMPLE_BITS-1]}}, x2_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_FF1: begin
        mul_a = g1_q;
        mul_b = {{(COEF_W-SUM1_W){sum1[SUM1_W-1]}}, sum1};
      end
      MUL_FB11: begin
        mul_a = a11_q;
        mul_b = m1_q;
      end
      MUL_FB12: begin
        mul_a = a12_q;
        mul_b = m2_q;
      end
      MUL_FB21: begin
        mul_a = a21_q;
        mul_b = y1_q;
      end
      MUL_FB22: begin
        mul_a = a22_q;
        mul_b = y2_q;
      end
      MUL_FF2A: begin
        mul_a = g2_q;
        mul_b = m1_q;
      end
      MUL_FF2B: begin
        mul_a = g2_q;
        mul_b = m2_q;
      end
      MUL_FF2C: begin
        mul_a = g2_q;
        mul_b = m_q;
      end
      default: ;
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign prod_r12 = prod_q + HALF12;
  assign prod_r28 = prod_q + HALF28;
  assign ff_r     = ff_q + HALF28_W;
  assign fb_v     = prod_r28[PROD_W-1:FRAC_COEF];
  assign ff_v     = ff_r[FF_W-1:FRAC_COEF];
  assign ff1_term = RES_W'(prod_r12[PROD_W-1:FF1_SHIFT]);
  assign fb_term  = RES_W'(fb_v);
  assign ff2_term = RES_W'(ff_v);

  always_comb begin
    case (cmd_i.res_op)
      RES_LOAD_FF1:    res_d = ff1_term;
      RES_SUB_FB:      res_d = res_q - fb_term;
      RES_LOAD_NEG_FB: res_d = -fb_term;
      RES_ADD_FF:      res_d = res_q + ff2_term;
      default:         res_d = res_q;
    endcase
  end

  always_comb begin
    case (cmd_i.ff_op)
      FF_LOAD_DBL: ff_d = FF_W'(prod_q) <<< 1;
      FF_ADD:      ff_d = ff_q + FF_W'(prod_q);
      default:     ff_d = ff_q;
    endcase
  end

  assign y_sat = sat32(res_q);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    ff_q   <= ff_d;
    res_q  <= res_d;
    if (cmd_i.take) begin
      x_q <= sample_i;
    end
    if (cmd_i.mid_load) begin
      m_q <= sat32(res_q);
    end
    if (cmd_i.commit) begin
      out_q <= y_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      m1_q <= '0;
      m2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (cmd_i.commit) begin
      x1_q <= x_q;
      x2_q <= x1_q;
      m1_q <= m_q;
      m2_q <= m1_q;
      y1_q <= y_sat;
      y2_q <= y1_q;
    end
  end

  assign filtered_o = out_q;

endmodule

// ===== rtl/core/bwlp_checker.sv =====
// Port-level checks for the fourth-order low-pass filter top level.
// Depends on bwlp_pkg; bound to butterworth_lowpass_4th_order.
module bwlp_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    sample_valid_i,
  input logic                                    sample_ready_o,
  input logic                                    filtered_valid_o,
  input logic                                    filtered_ready_i,
  input logic signed [bwlp_pkg::OUT_W-1:0]       filtered_o
);
  import bwlp_pkg::*;

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filtered_valid_o && !filtered_ready_i |=> filtered_valid_o)
    else $error("filtered valid dropped before transfer");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filtered_valid_o && !filtered_ready_i |=> $stable(filtered_o))
    else $error("filtered data changed while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && sample_ready_o |=> !sample_ready_o)
    else $error("sample taken while previous item in work");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(filtered_valid_o) |-> $past(!sample_ready_o))
    else $error("result appeared while idle");

endmodule

bind butterworth_lowpass_4th_order bwlp_checker u_bwlp_checker (.*);
